// File: hw/rtl/tile_switch_delta_packer_top_defines.svh
// Assertion helpers for the packer RTL.
`ifndef TILE_SWITCH_DELTA_PACKER_TOP_DEFINES_SVH
`define TILE_SWITCH_DELTA_PACKER_TOP_DEFINES_SVH

// Clocked on clk_i, off while rst_ni is low.
`define TSDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// At most one bit of the vector is set.
`define TSDP_ASSERT_ONEHOT0(lbl, vec, msg) \
  `TSDP_ASSERT(lbl, $onehot0(vec), msg)

`endif

// File: hw/rtl/tsdp_pkg.sv
package tsdp_pkg;

  localparam int GROUP_SIZE = 8;
  localparam int FILL_W     = $clog2(GROUP_SIZE + 1);
  localparam int IDX_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

  // s_axis tdata: x, y, tile, flip_x, flip_y, layer, list_first, list_length
  localparam int IN_W = 40;

  typedef struct packed {
    logic        layer;
    logic        flip_y;
    logic        flip_x;
    logic [13:0] tile;
    logic [6:0]  y;
    logic [6:0]  x;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_MASK  = 4'b0100,
    S_REC   = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;        // take the input record
    logic count_step;  // send count byte if pending, then clear it
    logic mask_emit;   // send the group's layer mask
    logic rec_emit;    // send current byte of current record
  } cmd_t;

  typedef struct packed {
    logic flush_req;   // input record closes a group
    logic count_pend;  // count byte waiting
    logic out_free;    // output register can take a byte
    logic rec_end;     // current byte is the record's last
    logic grp_end;     // current record is the group's last
  } sts_t;

endpackage

// File: hw/rtl/tsdp_ctrl.sv
`include "tile_switch_delta_packer_top_defines.svh"

module tsdp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  tsdp_pkg::sts_t sts_i,
  output tsdp_pkg::cmd_t cmd_o
);
  import tsdp_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.flush_req) state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (!sts_i.count_pend || sts_i.out_free) begin
          cmd_o.count_step = 1'b1;
          state_d          = S_MASK;
        end
      end
      S_MASK: begin
        if (sts_i.out_free) begin
          cmd_o.mask_emit = 1'b1;
          state_d         = S_REC;
        end
      end
      S_REC: begin
        if (sts_i.out_free) begin
          cmd_o.rec_emit = 1'b1;
          if (sts_i.rec_end && sts_i.grp_end) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TSDP_ASSERT(a_flush_starts, cmd_o.load && sts_i.flush_req |=> state_q == S_COUNT, "flush not started")
  `TSDP_ASSERT(a_flush_ends, cmd_o.rec_emit && sts_i.rec_end && sts_i.grp_end |=> s_ready_o, "flush did not end")
  `TSDP_ASSERT_ONEHOT0(a_one_cmd, cmd_o, "several commands at once")

endmodule

// File: hw/rtl/tsdp_datapath.sv
module tsdp_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tsdp_pkg::IN_W-1:0]  in_data_i,
  input  logic                       in_last_i,
  input  tsdp_pkg::cmd_t             cmd_i,
  output tsdp_pkg::sts_t             sts_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [7:0]                 m_data_o,
  output logic                       m_last_o,
  output logic                       m_user_o
);
  import tsdp_pkg::*;

  rec_t              grp_buf_q [GROUP_SIZE];
  logic [FILL_W-1:0] fill_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [1:0]        byte_idx_q;
  logic [6:0]        prev_x_q, prev_y_q;
  logic [13:0]       prev_tile_q;
  logic              prev_valid_q;
  logic [8:0]        count_q;
  logic              flush_last_q;
  logic              out_valid_q, out_last_q, out_user_q;
  logic [7:0]        out_byte_q;

  // input record
  rec_t              in_rec;
  logic              in_first;
  logic [7:0]        in_len;
  logic [IDX_W-1:0]  wr_idx;
  logic [FILL_W-1:0] fill_next;

  assign in_rec.x      = in_data_i[6:0];
  assign in_rec.y      = in_data_i[13:7];
  assign in_rec.tile   = in_data_i[27:14];
  assign in_rec.flip_x = in_data_i[28];
  assign in_rec.flip_y = in_data_i[29];
  assign in_rec.layer  = in_data_i[30];
  assign in_first      = in_data_i[31];
  assign in_len        = in_data_i[39:32];

  assign wr_idx    = in_first ? '0 : fill_q[IDX_W-1:0];
  assign fill_next = FILL_W'(wr_idx) + FILL_W'(1);

  // group mask
  logic [7:0] mask;
  always_comb begin
    mask = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (FILL_W'(i) < fill_q) mask[i] = grp_buf_q[i].layer;
    end
  end

  // record encoding
  rec_t        cur;
  logic [7:0]  dx, dy;
  logic [14:0] dt;
  logic        rel_pos, rel_tile;
  logic [7:0]  pos_b0, pos_b1, tile_b0, tile_b1, rec_byte;
  logic [1:0]  tile_sel, last_idx;

  assign cur = grp_buf_q[rd_idx_q];
  assign dx  = {1'b0, cur.x} - {1'b0, prev_x_q};
  assign dy  = {1'b0, cur.y} - {1'b0, prev_y_q};
  assign dt  = {1'b0, cur.tile} - {1'b0, prev_tile_q};

  assign rel_pos  = prev_valid_q && (dx[7:2] == '0 || dx[7:2] == '1) && dy[7:3] == '0;
  assign rel_tile = prev_valid_q && (dt[14:5] == '0 || dt[14:5] == '1);

  assign pos_b0  = rel_pos ? {1'b1, rel_tile, dx[2:0], dy[2:0]} : {1'b0, cur.x};
  assign pos_b1  = {rel_tile, cur.y};
  assign tile_b0 = rel_tile ? {cur.flip_x, cur.flip_y, dt[5:0]} : cur.tile[7:0];
  assign tile_b1 = {cur.flip_x, cur.flip_y, cur.tile[13:8]};

  assign tile_sel = byte_idx_q - (rel_pos ? 2'd1 : 2'd2);
  assign last_idx = 2'd1 + {1'b0, ~rel_pos} + {1'b0, ~rel_tile};

  always_comb begin
    if (byte_idx_q == 2'd0) begin
      rec_byte = pos_b0;
    end else if (!rel_pos && byte_idx_q == 2'd1) begin
      rec_byte = pos_b1;
    end else begin
      rec_byte = tile_sel[0] ? tile_b1 : tile_b0;
    end
  end

  logic out_free, emit, grp_done;
  assign out_free = !out_valid_q || m_ready_i;
  assign emit     = (cmd_i.count_step && count_q[8]) || cmd_i.mask_emit || cmd_i.rec_emit;
  assign grp_done = cmd_i.rec_emit && sts_o.rec_end && sts_o.grp_end;

  assign sts_o.flush_req  = in_last_i || fill_next == FILL_W'(GROUP_SIZE);
  assign sts_o.count_pend = count_q[8];
  assign sts_o.out_free   = out_free;
  assign sts_o.rec_end    = byte_idx_q == last_idx;
  assign sts_o.grp_end    = FILL_W'(rd_idx_q) + FILL_W'(1) == fill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) grp_buf_q[wr_idx] <= in_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      rd_idx_q     <= '0;
      byte_idx_q   <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_tile_q  <= '0;
      prev_valid_q <= 1'b0;
      count_q      <= '0;
      flush_last_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        fill_q       <= fill_next;
        flush_last_q <= in_last_i;
        if (in_first) begin
          prev_valid_q <= 1'b0;
          count_q      <= {1'b1, in_len};
        end
      end
      if (cmd_i.count_step) count_q <= '0;
      if (cmd_i.rec_emit) begin
        if (sts_o.rec_end) begin
          prev_x_q     <= cur.x;
          prev_y_q     <= cur.y;
          prev_tile_q  <= cur.tile;
          // a list end leaves no previous record behind
          prev_valid_q <= !(sts_o.grp_end && flush_last_q);
          byte_idx_q   <= '0;
          if (sts_o.grp_end) begin
            rd_idx_q <= '0;
            fill_q   <= '0;
            if (flush_last_q) count_q <= '0;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end else begin
          byte_idx_q <= byte_idx_q + 2'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (cmd_i.count_step) begin
        out_byte_q <= count_q[7:0];
      end else if (cmd_i.mask_emit) begin
        out_byte_q <= mask;
      end else begin
        out_byte_q <= rec_byte;
      end
      out_last_q <= grp_done;
      out_user_q <= grp_done && flush_last_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_byte_q;
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_user_q;

endmodule

// File: hw/rtl/tile_switch_delta_packer_top.sv
// Tile-switch delta packer.
// s_axis takes one tile-switch record per transaction; list_last rides on tlast.
// Records of a group are buffered (up to eight); a group is packed when it fills
// or when list_last arrives. m_axis then carries the packed bytes: the list's
// count byte (once, if list_first was seen), the group's layer mask, then per
// record 1 or 2 position bytes and 1 or 2 tile bytes. tlast marks the final byte
// of each packed group, tuser the final byte of a whole list.
// Flow: records that do not close a group are taken back to back. A closing
// record is taken, then the flush sequencer runs its count step, the mask and
// 2 to 4 bytes per buffered record, one byte per cycle through the single output
// register while m_axis_tready allows; s_axis_tready stays low for the
// whole flush. A pending count byte is loaded into the output register in
// S_COUNT after the closing record's transaction; without one, the mask byte,
// loaded in S_MASK, is the first byte out.
// Stalls: m_axis_tready low holds the output register and freezes the sequencer
// whenever it has a byte to send.
// Reset: clears the buffer fill, previous-record state and any pending count byte.
module tile_switch_delta_packer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [6:0] pos_x, [13:7] pos_y, [27:14] tile_index, [28] flip_x, [29] flip_y,
  // [30] layer_bit, [31] list_first, [39:32] list_length
  input  logic [tsdp_pkg::IN_W-1:0] s_axis_tdata_i,
  input  logic                      s_axis_tlast_i,   // list_last
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]                m_axis_tdata_o,
  output logic                      m_axis_tlast_o,   // run_last
  output logic                      m_axis_tuser_o    // [0] list_done
);
  import tsdp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsdp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tsdp_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (s_axis_tdata_i),
    .in_last_i (s_axis_tlast_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o),
    .m_user_o  (m_axis_tuser_o)
  );

endmodule
